[rtl/genpm_pkg.sv]
// ----------------------------------------------------------------------------
// genpm_pkg
// Shared types and constants for the greedy exclusive nearest-point matcher.
// ----------------------------------------------------------------------------
package genpm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int RESULT_CAP = 64;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int ABS_W      = COORD_BITS;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int DIST_W     = 34;

    localparam logic [1:0] CMD_LOAD_FLOAT = 2'd0;
    localparam logic [1:0] CMD_LOAD_REF   = 2'd1;
    localparam logic [1:0] CMD_RUN        = 2'd2;

    localparam logic [CNT_W-1:0] NUM_POINTS_RESET = CNT_W'(64);

    typedef struct packed {
        logic [1:0]         cmd;
        logic [IDX_W-1:0]   point_index;
        logic signed [15:0] coord_x;
        logic signed [15:0] coord_y;
        logic signed [15:0] coord_z;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  floating_index;
        logic [IDX_W-1:0]  matched_index;
        logic [DIST_W-1:0] distance_sq;
        logic              last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic             wr_float;
        logic             wr_ref;
        logic             clr_taken;
        logic             rd_float;
        logic             clr_best;
        logic             issue;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] j_idx;
        logic [IDX_W-1:0] k_idx;
    } genpm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pipe_busy;
    } genpm_stat_t;

endpackage

[rtl/genpm_ctrl.sv]
// ----------------------------------------------------------------------------
// genpm_ctrl
// Sequencer: decodes commands, holds the point count, steps the floating and
// reference counters through each run.
// ----------------------------------------------------------------------------
module genpm_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [1:0]                     cmd,
    output logic                           busy,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [genpm_pkg::CNT_W-1:0]    cfg_data,
    input  genpm_pkg::genpm_stat_t         stat,
    output genpm_pkg::genpm_cmd_t          ctl
);
    import genpm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOADF,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] num_points_reg;
    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] k_reg;

    logic             accept;
    logic             is_float;
    logic             is_ref;
    logic             is_run;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] cap;
    logic             j_last;
    logic             k_last;

    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        is_float = 1'b0;
        is_ref   = 1'b0;
        is_run   = 1'b0;
        unique case (cmd)
            CMD_LOAD_FLOAT: is_float = 1'b1;
            CMD_LOAD_REF:   is_ref   = 1'b1;
            CMD_RUN:        is_run   = 1'b1;
            default:        ;
        endcase
    end

    // count saturates at the store depth and at the result cap
    assign cap    = (MAX_POINTS < RESULT_CAP) ? CNT_W'(MAX_POINTS) : CNT_W'(RESULT_CAP);
    assign n_eff  = (num_points_reg > cap) ? cap : num_points_reg;
    assign j_last = ((j_reg + CNT_W'(1)) == n_reg);
    assign k_last = ((k_reg + CNT_W'(1)) == n_reg);

    always_comb
    begin
        ctl.wr_float  = accept && is_float;
        ctl.wr_ref    = accept && is_ref;
        ctl.clr_taken = accept && is_run;
        ctl.rd_float  = (state_reg == ST_LOADF);
        ctl.clr_best  = (state_reg == ST_LOADF);
        ctl.issue     = (state_reg == ST_SCAN);
        ctl.emit      = (state_reg == ST_EMIT);
        ctl.last      = j_last;
        ctl.j_idx     = j_reg[IDX_W-1:0];
        ctl.k_idx     = k_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            num_points_reg <= NUM_POINTS_RESET;
            n_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                num_points_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && is_run)
                    begin
                        n_reg <= n_eff;
                        j_reg <= '0;
                        if (n_eff != '0)
                        begin
                            state_reg <= ST_LOADF;
                        end
                    end
                end
                ST_LOADF:
                begin
                    k_reg     <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (k_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        k_reg <= k_reg + CNT_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!stat.pipe_busy)
                    begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (j_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        j_reg     <= j_reg + CNT_W'(1);
                        state_reg <= ST_LOADF;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/genpm_dpath.sv]
// ----------------------------------------------------------------------------
// genpm_dpath
// Point stores, taken marks, four-stage distance pipeline and the running
// minimum, plus the result register.
// ----------------------------------------------------------------------------
module genpm_dpath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  genpm_pkg::in_item_t    item,
    input  genpm_pkg::genpm_cmd_t  ctl,
    output genpm_pkg::genpm_stat_t stat,
    output logic                   result_valid,
    output genpm_pkg::out_item_t   result
);
    import genpm_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } point_t;

    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [COORD_BITS-1:0] a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [COORD_BITS:0] d;
        logic signed [COORD_BITS:0] m;
        begin
            d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
            m = d[COORD_BITS] ? -d : d;
            return m[ABS_W-1:0];
        end
    endfunction

    point_t float_mem [0:MAX_POINTS-1];
    point_t ref_mem   [0:MAX_POINTS-1];

    point_t                 load_pt;
    logic                   slot_ok;

    logic [MAX_POINTS-1:0]  taken_reg;
    point_t                 f_reg;
    point_t                 r_reg;

    logic                   s1_valid_reg;
    logic [IDX_W-1:0]       s1_k_reg;
    logic                   s2_valid_reg;
    logic [IDX_W-1:0]       s2_k_reg;
    logic [ABS_W-1:0]       ad_reg [0:2];
    logic                   s3_valid_reg;
    logic [IDX_W-1:0]       s3_k_reg;
    logic [SQ_W-1:0]        sq_reg [0:2];
    logic                   s4_valid_reg;
    logic [IDX_W-1:0]       s4_k_reg;
    logic [DIST_W-1:0]      sum_reg;

    logic                   found_reg;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [DIST_W-1:0]      best_d_reg;
    logic                   better;

    out_item_t              result_reg;
    logic                   result_valid_reg;

    assign load_pt.x = item.coord_x[COORD_BITS-1:0];
    assign load_pt.y = item.coord_y[COORD_BITS-1:0];
    assign load_pt.z = item.coord_z[COORD_BITS-1:0];
    assign slot_ok   = ({1'b0, item.point_index} < (IDX_W + 1)'(MAX_POINTS));

    // stores and their registered read ports
    always_ff @(posedge clk)
    begin
        if (ctl.wr_float && slot_ok)
        begin
            float_mem[item.point_index] <= load_pt;
        end
        if (ctl.wr_ref && slot_ok)
        begin
            ref_mem[item.point_index] <= load_pt;
        end
        if (ctl.rd_float)
        begin
            f_reg <= float_mem[ctl.j_idx];
        end
        if (ctl.issue)
        begin
            r_reg <= ref_mem[ctl.k_idx];
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        s1_k_reg  <= ctl.k_idx;
        s2_k_reg  <= s1_k_reg;
        ad_reg[0] <= abs_diff(f_reg.x, r_reg.x);
        ad_reg[1] <= abs_diff(f_reg.y, r_reg.y);
        ad_reg[2] <= abs_diff(f_reg.z, r_reg.z);
        s3_k_reg  <= s2_k_reg;
        sq_reg[0] <= ad_reg[0] * ad_reg[0];
        sq_reg[1] <= ad_reg[1] * ad_reg[1];
        sq_reg[2] <= ad_reg[2] * ad_reg[2];
        s4_k_reg  <= s3_k_reg;
        sum_reg   <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
    end

    assign better = s4_valid_reg && (!found_reg || (sum_reg < best_d_reg));
    assign stat.pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg;

    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_idx_reg <= s4_k_reg;
            best_d_reg   <= sum_reg;
        end
        if (ctl.emit)
        begin
            result_reg.floating_index <= ctl.j_idx;
            result_reg.matched_index  <= best_idx_reg;
            result_reg.distance_sq    <= best_d_reg;
            result_reg.last           <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg        <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            s4_valid_reg     <= 1'b0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            // taken entries never enter the compare
            s1_valid_reg     <= ctl.issue && !taken_reg[ctl.k_idx];
            s2_valid_reg     <= s1_valid_reg;
            s3_valid_reg     <= s2_valid_reg;
            s4_valid_reg     <= s3_valid_reg;
            result_valid_reg <= ctl.emit;
            if (ctl.clr_best)
            begin
                found_reg <= 1'b0;
            end
            else if (better)
            begin
                found_reg <= 1'b1;
            end
            if (ctl.clr_taken)
            begin
                taken_reg <= '0;
            end
            else if (ctl.emit)
            begin
                taken_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/greedy_exclusive_nearest_point_match.sv]
// ----------------------------------------------------------------------------
// greedy_exclusive_nearest_point_match
// Greedy exclusive nearest-point matcher for two 3-D point sets.
// ----------------------------------------------------------------------------
// Usage:
//   A command transaction is taken when start is high and busy is low.
//   Load commands write one point into the floating or reference store;
//   busy stays low.
//   A run command raises busy and handles floating points 0 .. n-1 in order,
//   where n is num_points saturated at 64. Per floating point: a read step,
//   a scan of reference points 0 .. n-1 (one reference store read per
//   cycle), a drain of the distance pipeline and an emit step.
//   Each result appears for one cycle with result_valid high, the cycle after
//   its emit step; last marks the final one. A run with n of zero gives no
//   results and leaves busy low. The receiver cannot stall, so nothing is buffered.
//   num_points is written on the cfg channel (always ready) while idle.
//   Reset clears the controller, the pipeline and the taken marks and sets
//   num_points to 64; the point stores hold nothing until loaded.
// ----------------------------------------------------------------------------
module greedy_exclusive_nearest_point_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  genpm_pkg::in_item_t         item,
    output logic                        result_valid,
    output genpm_pkg::out_item_t        result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [genpm_pkg::CNT_W-1:0] cfg_data
);
    import genpm_pkg::*;

    genpm_cmd_t  ctl;
    genpm_stat_t stat;

    genpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (item.cmd),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .ctl       (ctl)
    );

    genpm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .ctl          (ctl),
        .stat         (stat),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/tb_greedy_exclusive_nearest_point_match.sv]
// ----------------------------------------------------------------------------
// tb_greedy_exclusive_nearest_point_match
// Self-checking bench for the greedy nearest-point matcher. Loads floating and
// reference points, issues runs at several point counts and compares every
// result against a predictor that repeats the greedy search in the bench.
// ----------------------------------------------------------------------------
module tb_greedy_exclusive_nearest_point_match;

    import genpm_pkg::*;

    localparam int         DRAIN_CYCLES = 100;
    localparam int         CYCLE_LIMIT  = 10_000_000;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } point_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    in_item_t         item      = '0;
    logic             cfg_valid = 1'b0;
    logic [CNT_W-1:0] cfg_data  = '0;
    logic             busy;
    logic             result_valid;
    out_item_t        result;
    logic             cfg_ready;

    // bench copy of the block state
    point_t           float_pts    [MAX_POINTS];
    point_t           ref_pts      [MAX_POINTS];
    bit               float_loaded [MAX_POINTS];
    bit               ref_loaded   [MAX_POINTS];
    logic [CNT_W-1:0] point_count = NUM_POINTS_RESET;

    out_item_t        expected_matches[$];
    out_item_t        want;
    int               err_count  = 0;
    int               items_sent = 0;
    int               cur_idle   = 0;
    int               cycles     = 0;

    greedy_exclusive_nearest_point_match i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("greedy_exclusive_nearest_point_match test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [DIST_W-1:0] squared_distance(point_t a, point_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = longint'($signed(a.x)) - longint'($signed(b.x));
        dy = longint'($signed(a.y)) - longint'($signed(b.y));
        dz = longint'($signed(a.z)) - longint'($signed(b.z));
        return DIST_W'(dx * dx + dy * dy + dz * dz);
    endfunction

    function automatic void predict_matches();
        bit                taken [MAX_POINTS];
        int                n;
        int                best;
        bit                found;
        logic [DIST_W-1:0] best_d;
        logic [DIST_W-1:0] d;
        out_item_t         r;
        n = (point_count > RESULT_CAP) ? RESULT_CAP : int'(point_count);
        for (int j = 0; j < n; j++)
        begin
            found  = 1'b0;
            best   = 0;
            best_d = '0;
            for (int k = 0; k < n; k++)
            begin
                if (!taken[k])
                begin
                    d = squared_distance(float_pts[j], ref_pts[k]);
                    // strict compare: lowest index wins a tie
                    if (!found || d < best_d)
                    begin
                        found  = 1'b1;
                        best   = k;
                        best_d = d;
                    end
                end
            end
            if (found)
                taken[best] = 1'b1;
            r.floating_index = IDX_W'(j);
            r.matched_index  = IDX_W'(best);
            r.distance_sq    = best_d;
            r.last           = (j == n - 1);
            expected_matches.push_back(r);
        end
    endfunction

    function automatic void apply_command(in_item_t it);
        case (it.cmd)
            CMD_LOAD_FLOAT:
            begin
                float_pts[it.point_index]    = '{it.coord_x, it.coord_y, it.coord_z};
                float_loaded[it.point_index] = 1'b1;
            end
            CMD_LOAD_REF:
            begin
                ref_pts[it.point_index]    = '{it.coord_x, it.coord_y, it.coord_z};
                ref_loaded[it.point_index] = 1'b1;
            end
            CMD_RUN:
                predict_matches();
            default:
                ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_matches.size() == 0)
            begin
                $error("result with nothing expected: floating_index %0d",
                       result.floating_index);
                err_count++;
            end
            else
            begin
                want = expected_matches.pop_front();
                check_field("floating_index", want.floating_index, result.floating_index);
                check_field("matched_index", want.matched_index, result.matched_index);
                check_field("distance_sq", want.distance_sq, result.distance_sq);
                check_field("last", want.last, result.last);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2, 3, 4: return 16'($signed($urandom_range(6)) - 3);  // clustered, gives ties
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic in_item_t rand_item();
        in_item_t it;
        it.cmd         = 2'($urandom_range(3));
        it.point_index = IDX_W'($urandom_range(MAX_POINTS - 1));
        it.coord_x     = rand_coord();
        it.coord_y     = rand_coord();
        it.coord_z     = rand_coord();
        return it;
    endfunction

    // start stays high across back-to-back transactions
    task automatic send_item(in_item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_command(it);
        if (it.cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic idle_gap(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic load_point(logic [1:0] cmd, int idx, point_t p);
        in_item_t it;
        it.cmd         = cmd;
        it.point_index = IDX_W'(idx);
        it.coord_x     = p.x;
        it.coord_y     = p.y;
        it.coord_z     = p.z;
        send_item(it);
        idle_gap(cur_idle);
    endtask

    task automatic run_match();
        in_item_t it;
        it     = rand_item();
        it.cmd = CMD_RUN;
        send_item(it);
        idle_gap(cur_idle);
    endtask

    // block idle: all results in, busy low, short settle for runs with no output
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (expected_matches.size() != 0)
            @(posedge clk);
        while (busy)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid   <= 1'b0;
        point_count = value;
    endtask

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return CNT_W'(64);
        else if (r < 5)
            return CNT_W'($urandom_range(65, 127));
        else if (r < 8)
            return '0;
        else if (r < 16)
            return CNT_W'($urandom_range(9, 63));
        return CNT_W'($urandom_range(1, 8));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_extreme_coordinates();
        write_count(CNT_W'(1));
        load_point(CMD_LOAD_FLOAT, 0, '{16'sh8000, 16'sh8000, 16'sh8000});
        load_point(CMD_LOAD_REF, 0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        run_match();
        load_point(CMD_LOAD_FLOAT, 0, '{16'sh7FFF, 16'sh8000, 16'sh0000});
        load_point(CMD_LOAD_REF, 0, '{16'sh8000, 16'sh7FFF, 16'shFFFF});
        run_match();
    endtask

    // equal distances pick the lowest index; a taken point is skipped
    task automatic test_tie_break();
        write_count(CNT_W'(3));
        load_point(CMD_LOAD_REF, 0, '{16'sd10, 16'sd0, 16'sd0});
        load_point(CMD_LOAD_REF, 1, '{-16'sd10, 16'sd0, 16'sd0});
        load_point(CMD_LOAD_REF, 2, '{16'sd10, 16'sd0, 16'sd0});
        load_point(CMD_LOAD_FLOAT, 0, '{16'sd0, 16'sd0, 16'sd0});
        load_point(CMD_LOAD_FLOAT, 1, '{16'sd10, 16'sd0, 16'sd0});
        load_point(CMD_LOAD_FLOAT, 2, '{16'sd10, 16'sd0, 16'sd0});
        run_match();
    endtask

    // marks must be cleared by each run, so back-to-back runs agree
    task automatic test_taken_marks();
        run_match();
        run_match();
    endtask

    task automatic test_ignored_command();
        in_item_t it;
        repeat (2)
        begin
            it     = rand_item();
            it.cmd = CMD_UNUSED;
            send_item(it);
            idle_gap(cur_idle);
        end
        run_match();
    endtask

    task automatic test_zero_count();
        write_count('0);
        run_match();
        run_match();
    endtask

    task automatic test_random_traffic(int idle_pct, int num_items, logic [CNT_W-1:0] first_count);
        in_item_t         batch[$];
        in_item_t         it;
        in_item_t         tmp;
        int               target;
        int               n;
        int               j;
        bit               reconfig;
        logic [CNT_W-1:0] cnt;
        cur_idle = idle_pct;
        target   = items_sent + num_items;
        cnt      = first_count;
        reconfig = 1'b1;
        while (items_sent < target)
        begin
            if (reconfig)
                write_count(cnt);
            n = (point_count > RESULT_CAP) ? RESULT_CAP : int'(point_count);
            batch.delete();
            // every slot a run reads must hold a loaded point
            for (int i = 0; i < n; i++)
            begin
                if (!float_loaded[i] || $urandom_range(3) != 0)
                begin
                    it             = rand_item();
                    it.cmd         = CMD_LOAD_FLOAT;
                    it.point_index = IDX_W'(i);
                    batch.push_back(it);
                end
                if (!ref_loaded[i] || $urandom_range(3) != 0)
                begin
                    it             = rand_item();
                    it.cmd         = CMD_LOAD_REF;
                    it.point_index = IDX_W'(i);
                    batch.push_back(it);
                end
            end
            repeat ($urandom_range(2))
            begin
                it = rand_item();
                if (it.cmd == CMD_RUN)
                    it.cmd = CMD_UNUSED;
                batch.push_back(it);
            end
            for (int i = batch.size() - 1; i > 0; i--)
            begin
                j        = $urandom_range(i);
                tmp      = batch[i];
                batch[i] = batch[j];
                batch[j] = tmp;
            end
            foreach (batch[i])
            begin
                send_item(batch[i]);
                idle_gap(idle_pct);
            end
            if ($urandom_range(9) != 0)
                run_match();
            reconfig = ($urandom_range(99) < 40);
            cnt      = pick_count();
        end
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_idle = 13;
        test_extreme_coordinates();
        test_tie_break();
        test_taken_marks();
        test_ignored_command();
        test_zero_count();

        test_random_traffic(13, 140, CNT_W'(64));
        test_random_traffic(88, 140, CNT_W'(127));
        test_random_traffic(0, 140, CNT_W'(1));

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (err_count == 0)
            $display("greedy_exclusive_nearest_point_match test passed");
        else
            $display("greedy_exclusive_nearest_point_match test failed");
        $finish;
    end

endmodule
